[design/urf_pkg.sv]
// Shared types, constants and the digit-character helper function of the unsigned radix formatter.
package urf_pkg;

  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned OP_W           = 3;
  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned PREC_W         = 7;
  localparam int unsigned CNT_W          = 7;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 7;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned BCD_DIGITS     = 20;
  localparam int unsigned BCD_W          = BCD_DIGITS * DIGIT_W;
  localparam int unsigned DD_BITS        = 4;
  localparam int unsigned DD_CYCLES      = VALUE_W / DD_BITS;
  localparam int unsigned PREC_LIMIT     = 60;
  localparam int unsigned MAX_DIGITS_DEF = 64;

  localparam logic [PREC_W-1:0] PREC_RESET = 7'h7F;

  localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CH_X_LO    = 7'h78;
  localparam logic [CHAR_W-1:0] CH_X_UP    = 7'h58;

  typedef enum logic [OP_W-1:0] {
    OP_DEC    = 3'd0,
    OP_OCT    = 3'd1,
    OP_HEX_LO = 3'd2,
    OP_HEX_UP = 3'd3,
    OP_PTR    = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRECISION = 1'b0,
    REG_ALTERNATE = 1'b1
  } reg_idx_e;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      return CH_ZERO + dx;
    end
    return (upper ? CH_UPPER_A : CH_LOWER_A) + dx - 7'd10;
  endfunction

endpackage

[design/urf_dabble.sv]
// Combinational binary to BCD shift-and-add-3 unit, advancing DD_BITS (4) bits per pass.
module urf_dabble (
  input  logic [urf_pkg::BCD_W-1:0]   bcd_i,
  input  logic [urf_pkg::VALUE_W-1:0] bin_i,
  output logic [urf_pkg::BCD_W-1:0]   bcd_o,
  output logic [urf_pkg::VALUE_W-1:0] bin_o
);
  import urf_pkg::*;

  always_comb begin
    logic [BCD_W-1:0]   b;
    logic [VALUE_W-1:0] v;
    b = bcd_i;
    v = bin_i;
    for (int s = 0; s < DD_BITS; s++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (b[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
          b[d*DIGIT_W +: DIGIT_W] = b[d*DIGIT_W +: DIGIT_W] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], v[VALUE_W-1]};
      v = {v[VALUE_W-2:0], 1'b0};
    end
    bcd_o = b;
    bin_o = v;
  end

endmodule

[design/unsigned_radix_formatter_top.sv]
// Top level of the unsigned radix formatter: sequencer, digit store and output register.
//
// An item is taken when start_i is high and busy_o is low; busy_o stays high until the
// last character has been launched. A decimal item first passes through the
// binary-to-BCD unit, 4 bits a cycle. Every item then peels its d significant digits
// into the digit store, one per cycle through the shared shifter, then passes a setup
// state, and then emits one character per cycle, prefix included. Each character
// is shown on char_out_o with result_valid_o for exactly one cycle, and the receiver
// cannot hold it off. An item that produces no characters shows no strobe at all.
// Registers are written only while the block is idle; cfg_ready_o is low while busy.
module unsigned_radix_formatter_top #(
  parameter int unsigned MAX_DIGITS = urf_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [urf_pkg::VALUE_W-1:0]   value_i,
  input  logic [urf_pkg::OP_W-1:0]      operation_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [urf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [urf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                          result_valid_o,
  output logic [urf_pkg::CHAR_W-1:0]    char_out_o,
  output logic                          last_o
);
  import urf_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_DIGITS);
  localparam int unsigned IterW = $clog2(DD_CYCLES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BCD,
    ST_STORE,
    ST_SETUP,
    ST_PFX0,
    ST_PFX1,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX
  } radix_e;

  state_e             state_q, state_d;
  radix_e             radix_q, radix_d;
  logic               upper_q, upper_d;
  logic               alt_q, alt_d;
  logic               pfx_two_q, pfx_two_d;
  logic [BCD_W-1:0]   work_q, work_d;
  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [IterW-1:0]   iter_q, iter_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [PREC_W-1:0]  prec_q, prec_d;
  logic               alt_reg_q, alt_reg_d;
  logic               valid_q, valid_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               last_q, last_d;

  logic [BCD_W-1:0]   dd_bcd;
  logic [VALUE_W-1:0] dd_bin;
  logic [DIGIT_W-1:0] low_digit;
  logic [CNT_W-1:0]   prec_sat, len_floor, len, len_m1, pos_m1;
  logic [AddrW-1:0]   rd_addr;
  logic [DIGIT_W-1:0] rd_data_q;
  logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];
  logic               mem_we;

  urf_dabble u_dabble (
    .bcd_i (work_q),
    .bin_i (bin_q),
    .bcd_o (dd_bcd),
    .bin_o (dd_bin)
  );

  assign low_digit = (radix_q == RADIX_OCT) ? {1'b0, work_q[2:0]} : work_q[DIGIT_W-1:0];

  assign prec_sat  = (prec_q[5:0] > 6'(PREC_LIMIT)) ? CNT_W'(PREC_LIMIT)
                                                    : {1'b0, prec_q[5:0]};
  assign len_floor = prec_q[PREC_W-1] ? CNT_W'(1) : prec_sat;
  assign len       = (cnt_q > len_floor) ? cnt_q : len_floor;
  assign len_m1    = len - CNT_W'(1);
  assign pos_m1    = pos_q - CNT_W'(1);
  assign rd_addr   = (state_q == ST_EMIT) ? pos_m1[AddrW-1:0] : len_m1[AddrW-1:0];
  assign mem_we    = (state_q == ST_STORE) && (work_q != '0) &&
                     (cnt_q < CNT_W'(MAX_DIGITS));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[cnt_q[AddrW-1:0]] <= low_digit;
    end
    rd_data_q <= digit_mem[rd_addr];
  end

  always_comb begin
    state_d   = state_q;
    radix_d   = radix_q;
    upper_d   = upper_q;
    alt_d     = alt_q;
    pfx_two_d = pfx_two_q;
    work_d    = work_q;
    bin_d     = bin_q;
    iter_d    = iter_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    prec_d    = prec_q;
    alt_reg_d = alt_reg_q;
    valid_d   = 1'b0;
    char_d    = char_q;
    last_d    = 1'b0;

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PRECISION: prec_d    = cfg_data_i;
        REG_ALTERNATE: alt_reg_d = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cnt_d   = '0;
          iter_d  = '0;
          upper_d = 1'b0;
          alt_d   = alt_reg_d;
          case (operation_i)
            OP_OCT: radix_d = RADIX_OCT;
            OP_HEX_LO: begin
              radix_d = RADIX_HEX;
              if (value_i == '0) alt_d = 1'b0;
            end
            OP_HEX_UP: begin
              radix_d = RADIX_HEX;
              upper_d = 1'b1;
              if (value_i == '0) alt_d = 1'b0;
            end
            OP_PTR: begin
              radix_d = RADIX_HEX;
              alt_d   = 1'b1;
            end
            default: radix_d = RADIX_DEC;
          endcase
          if (radix_d == RADIX_DEC) begin
            work_d  = '0;
            bin_d   = value_i;
            state_d = ST_BCD;
          end else begin
            work_d  = {{(BCD_W-VALUE_W){1'b0}}, value_i};
            state_d = ST_STORE;
          end
        end
      end
      ST_BCD: begin
        work_d = dd_bcd;
        bin_d  = dd_bin;
        iter_d = iter_q + IterW'(1);
        if (iter_q == IterW'(DD_CYCLES - 1)) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        if (mem_we) begin
          work_d = (radix_q == RADIX_OCT) ? (work_q >> 3) : (work_q >> DIGIT_W);
          cnt_d  = cnt_q + CNT_W'(1);
        end else begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        pos_d     = len_m1;
        pfx_two_d = (radix_q == RADIX_HEX);
        if (alt_q && ((radix_q == RADIX_HEX) ||
                      ((radix_q == RADIX_OCT) && (len == cnt_q)))) begin
          state_d = ST_PFX0;
        end else if (len != '0) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PFX0: begin
        valid_d = 1'b1;
        char_d  = CH_ZERO;
        last_d  = !pfx_two_q && (len == '0);
        if (pfx_two_q) begin
          state_d = ST_PFX1;
        end else if (len != '0) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PFX1: begin
        valid_d = 1'b1;
        char_d  = upper_q ? CH_X_UP : CH_X_LO;
        last_d  = (len == '0);
        state_d = (len != '0) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        valid_d = 1'b1;
        char_d  = (pos_q < cnt_q) ? digit_char(rd_data_q, upper_q) : CH_ZERO;
        last_d  = (pos_q == '0);
        pos_d   = pos_m1;
        if (pos_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      radix_q   <= RADIX_DEC;
      upper_q   <= 1'b0;
      alt_q     <= 1'b0;
      pfx_two_q <= 1'b0;
      work_q    <= '0;
      bin_q     <= '0;
      iter_q    <= '0;
      cnt_q     <= '0;
      pos_q     <= '0;
      prec_q    <= PREC_RESET;
      alt_reg_q <= 1'b0;
      valid_q   <= 1'b0;
      char_q    <= '0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      radix_q   <= radix_d;
      upper_q   <= upper_d;
      alt_q     <= alt_d;
      pfx_two_q <= pfx_two_d;
      work_q    <= work_d;
      bin_q     <= bin_d;
      iter_q    <= iter_d;
      cnt_q     <= cnt_d;
      pos_q     <= pos_d;
      prec_q    <= prec_d;
      alt_reg_q <= alt_reg_d;
      valid_q   <= valid_d;
      char_q    <= char_d;
      last_q    <= last_d;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign cfg_ready_o    = (state_q == ST_IDLE);
  assign result_valid_o = valid_q;
  assign char_out_o     = char_q;
  assign last_o         = last_q;

endmodule

[design/urf_checker.sv]
// Port-level checker of the unsigned radix formatter and its bind to the top level.
module urf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic result_valid_o,
  input logic last_o
);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("Accepted item did not make the block busy.");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("Result shown without a conversion in progress.");

  a_chars_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |=> result_valid_o)
    else $error("Gap inside the characters of one item.");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy_o)
    else $error("Block still busy after the final character.");

endmodule

bind unsigned_radix_formatter_top urf_checker u_urf_checker (.*);

[tb/urf_char_checker.sv]
// Checker for the unsigned radix formatter: predicts each conversion and compares the characters.
module urf_char_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic [urf_pkg::VALUE_W-1:0]    value_i,
  input  logic [urf_pkg::OP_W-1:0]       operation_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [urf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [urf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           result_valid_i,
  input  logic [urf_pkg::CHAR_W-1:0]     char_i,
  input  logic                           last_i,
  output int                             pending_o,
  output int                             errors_o,
  output int                             checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import urf_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_beat_t;

  char_beat_t        expected_chars[$];
  logic [PREC_W-1:0] precision_q;
  logic              alternate_q;
  int                mismatches;
  int                chars_checked;

  function automatic void predict_conversion(input logic [VALUE_W-1:0] v,
                                             input logic [OP_W-1:0] op);
    logic [DIGIT_W-1:0] digits[64];
    logic [VALUE_W-1:0] n;
    logic [VALUE_W-1:0] base;
    logic               upper;
    logic               alt;
    logic               has_prec;
    logic [DIGIT_W-1:0] d;
    int                 cnt;
    int                 prec;
    int                 len;
    int                 added;
    char_beat_t         beat;
    base  = 10;
    upper = 1'b0;
    case (op)
      OP_OCT:            base = 8;
      OP_HEX_LO, OP_PTR: base = 16;
      OP_HEX_UP: begin
        base  = 16;
        upper = 1'b1;
      end
      default:           base = 10;
    endcase
    alt = alternate_q;
    if (op == OP_PTR) begin
      alt = 1'b1;
    end else if ((op == OP_HEX_LO || op == OP_HEX_UP) && v == '0) begin
      alt = 1'b0;
    end
    n   = v;
    cnt = 0;
    while (n != '0) begin
      digits[cnt] = DIGIT_W'(n % base);
      n = n / base;
      cnt++;
    end
    has_prec = !precision_q[PREC_W-1];
    prec = int'(precision_q[PREC_W-2:0]);
    if (prec > PREC_LIMIT) begin
      prec = PREC_LIMIT;
    end
    len = cnt;
    if (!has_prec && len < 1) begin
      len = 1;
    end
    if (has_prec && prec > len) begin
      len = prec;
    end
    added     = 0;
    beat.last = 1'b0;
    if (alt && base == 8 && len == cnt) begin
      beat.ch = CH_ZERO;
      expected_chars.push_back(beat);
      added++;
    end else if (alt && base == 16) begin
      beat.ch = CH_ZERO;
      expected_chars.push_back(beat);
      beat.ch = upper ? CH_X_UP : CH_X_LO;
      expected_chars.push_back(beat);
      added += 2;
    end
    for (int pos = len - 1; pos >= 0; pos--) begin
      beat.ch = CH_ZERO;
      if (pos < cnt) begin
        d = digits[pos];
        if (d < 4'd10) begin
          beat.ch = CH_ZERO + CHAR_W'(d);
        end else begin
          beat.ch = (upper ? CH_UPPER_A : CH_LOWER_A) + CHAR_W'(d) - 7'd10;
        end
      end
      expected_chars.push_back(beat);
      added++;
    end
    if (added > 0) begin
      expected_chars[expected_chars.size()-1].last = 1'b1;
    end
  endfunction

  task automatic note_mismatch(input string what, input char_beat_t want,
                               input logic [CHAR_W-1:0] got_ch, input logic got_last);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected char %h last %b, got char %h last %b",
               $realtime, what, want.ch, want.last, got_ch, got_last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    char_beat_t want;
    if (!rst_ni) begin
      expected_chars.delete();
      precision_q   = PREC_RESET;
      alternate_q   = 1'b0;
      mismatches    = 0;
      chars_checked = 0;
    end else begin
      if (result_valid_i) begin
        if (expected_chars.size() == 0) begin
          want = '0;
          note_mismatch("character with none expected", want, char_i, last_i);
        end else begin
          want = expected_chars.pop_front();
          chars_checked++;
          if (want.ch !== char_i || want.last !== last_i) begin
            note_mismatch("character mismatch", want, char_i, last_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_PRECISION) begin
          precision_q = cfg_data_i[PREC_W-1:0];
        end else begin
          alternate_q = cfg_data_i[0];
        end
      end
      if (start_i && !busy_i) begin
        predict_conversion(value_i, operation_i);
      end
    end
    pending_o <= expected_chars.size();
    errors_o  <= mismatches;
    checked_o <= chars_checked;
  end

endmodule

[tb/unsigned_radix_formatter_top_tb.sv]
// Testbench top for the unsigned radix formatter: clock, reset, stimulus and verdict.
module unsigned_radix_formatter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import urf_pkg::*;

  localparam real CLK_PERIOD    = 4.0;
  localparam int  RESET_CYCLES  = 12;
  localparam int  SETTLE_CYCLES = 150;
  localparam int  STALL_LIMIT   = 4000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  logic                  busy_o;
  logic [VALUE_W-1:0]    value_i     = '0;
  logic [OP_W-1:0]       operation_i = OP_DEC;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_PRECISION;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  result_valid_o;
  logic [CHAR_W-1:0]     char_out_o;
  logic                  last_o;

  int pending;
  int errors;
  int checked;
  int items_sent = 0;
  int settings   = 0;
  int burst_left = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  unsigned_radix_formatter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .value_i        (value_i),
    .operation_i    (operation_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .char_out_o     (char_out_o),
    .last_o         (last_o)
  );

  urf_char_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .value_i        (value_i),
    .operation_i    (operation_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_i (result_valid_o),
    .char_i         (char_out_o),
    .last_i         (last_o),
    .pending_o      (pending),
    .errors_o       (errors),
    .checked_o      (checked)
  );

  task automatic send_item(input logic [VALUE_W-1:0] v, input logic [OP_W-1:0] op);
    start_i     <= 1'b1;
    value_i     <= v;
    operation_i <= op;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [PREC_W-1:0] prec, input logic alt);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_PRECISION;
    cfg_data_i  <= prec;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= REG_ALTERNATE;
    cfg_data_i  <= {6'($urandom), alt};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  task automatic run_phase(input logic [PREC_W-1:0] prec, input logic alt, input int count);
    logic [VALUE_W-1:0] v;
    logic [OP_W-1:0]    op;
    set_config(prec, alt);
    repeat (count) begin
      case ($urandom_range(0, 7))
        0:       v = '0;
        1:       v = '1;
        2:       v = VALUE_W'($urandom_range(0, 99));
        3:       v = VALUE_W'(1) << $urandom_range(0, 63);
        4:       v = (VALUE_W'(1) << $urandom_range(1, 63)) - VALUE_W'(1);
        5:       v = {$urandom, $urandom} >> $urandom_range(1, 60);
        default: v = {$urandom, $urandom};
      endcase
      if ($urandom_range(0, 11) == 0) begin
        op = OP_W'(OP_PTR) + OP_W'($urandom_range(1, 3));
      end else begin
        op = OP_W'($urandom_range(OP_DEC, OP_PTR));
      end
      send_item(v, op);
    end
    wait_idle();
  endtask

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || (cfg_valid_i && cfg_ready_o) || result_valid_o) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: no precision, no prefix.
    for (int o = OP_DEC; o <= OP_PTR; o++) begin
      send_item('0, OP_W'(o));
      send_item('1, OP_W'(o));
    end
    for (int o = OP_PTR + 1; o < (1 << OP_W); o++) begin
      send_item(VALUE_W'(64'd12345), OP_W'(o));
    end
    send_item(VALUE_W'(64'h8000_0000_0000_0000), OP_OCT);
    wait_idle();

    // Precision zero with a zero value gives no digits; prefix rules apply alone.
    set_config('0, 1'b1);
    for (int o = OP_DEC; o <= OP_PTR; o++) begin
      send_item('0, OP_W'(o));
    end
    send_item(VALUE_W'(64'd7), OP_OCT);
    send_item(VALUE_W'(64'd8), OP_OCT);
    wait_idle();

    run_phase(PREC_RESET, 1'b1, 30);
    run_phase('0, 1'b1, 30);
    run_phase('0, 1'b0, 30);
    run_phase(PREC_W'(PREC_LIMIT), 1'b1, 20);
    run_phase(PREC_W'(PREC_LIMIT + 3), 1'b0, 20);
    run_phase(PREC_W'(-64), 1'b1, 30);
    run_phase(PREC_W'(1), 1'b0, 30);
    run_phase(PREC_W'(22), 1'b1, 30);
    run_phase(PREC_W'($urandom_range(0, 127)), 1'($urandom), 40);
    run_phase(PREC_W'($urandom_range(0, 127)), 1'($urandom), 40);

    $display("Converted %0d items under %0d register settings plus the reset one.",
             items_sent, settings);
    $display("Compared %0d characters, %0d mismatches, %0d still expected.",
             checked, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/urf_pkg.sv
design/urf_dabble.sv
design/unsigned_radix_formatter_top.sv
design/urf_checker.sv
tb/urf_char_checker.sv
tb/unsigned_radix_formatter_top_tb.sv
